// ===== src/prbeo_pkg.sv =====
// Package for the polyline ribbon edge offset block
// Holds the transfer structs, the sequencer state type and the fixed constants
`timescale 1ns / 1ps
package prbeo_pkg;

    // one input point
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               is_final;
    } point_t;

    // one output pair
    typedef struct packed {
        logic signed [31:0] base_x;
        logic signed [31:0] base_y;
        logic signed [31:0] base_z;
        logic signed [31:0] edge_x;
        logic signed [31:0] edge_y;
        logic signed [31:0] edge_z;
        logic [15:0]        glow;
        logic               last_pair;
    } pair_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_NORM,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_DIVX,
        S_MULX,
        S_DIVY,
        S_MULY,
        S_VMUL,
        S_GLOW,
        S_GMOD,
        S_GDIV,
        S_OUT
    } seq_state_t;

    // configuration register indexes
    localparam logic [2:0] REG_IN_CTRL_X  = 3'd0;
    localparam logic [2:0] REG_IN_CTRL_Y  = 3'd1;
    localparam logic [2:0] REG_IN_CTRL_Z  = 3'd2;
    localparam logic [2:0] REG_OUT_CTRL_X = 3'd3;
    localparam logic [2:0] REG_OUT_CTRL_Y = 3'd4;
    localparam logic [2:0] REG_OUT_CTRL_Z = 3'd5;
    localparam logic [2:0] REG_WIDTH      = 3'd6;

    localparam logic [30:0] WIDTH_RESET   = 31'd65536;
    localparam logic [31:0] INV_SQRT2_Q30 = 32'd759250125;
    localparam logic [15:0] GLOW_ZERO_Z   = 16'd43691;
    localparam logic [63:0] ROUND_Q30     = 64'd536870912;

    // iteration counts of the shared units
    localparam logic [5:0] ROOT_STEPS = 6'd32;
    localparam logic [5:0] QDIV_STEPS = 6'd33;
    localparam logic [5:0] MOD_STEPS  = 6'd32;
    localparam logic [5:0] GDIV_STEPS = 6'd18;

endpackage

// ===== src/polyline_ribbon_edge_offset_top.sv =====
// Top level of the polyline ribbon edge offset block
// Depends on prbeo_pkg for transfer structs, state type and constants
`timescale 1ns / 1ps
// Each accepted point gives zero, one or two pairs, one point late. A pair is
// built by one sequencer around a shared 32x32 multiplier, a one-bit-a-cycle
// restoring divider and a one-bit-pair-a-cycle square root. A normal tangent
// is normalised, squared, rooted, then divided and scaled in x and y. A
// vertical tangent is scaled by 1/sqrt(2) instead and a zero tangent gets no
// offset. A point with zero z skips the intensity divides. The input is not
// ready while a pair is being made or waits for its transfer.
module polyline_ribbon_edge_offset_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  point_valid,
    output logic                  point_ready,
    input  prbeo_pkg::point_t     point,
    output logic                  pair_valid,
    input  logic                  pair_ready,
    output prbeo_pkg::pair_t      pair,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    prbeo_pkg::seq_state_t state_reg, state_next;

    // configuration
    logic signed [31:0] in_ctrl_reg  [3];
    logic signed [31:0] out_ctrl_reg [3];
    logic [30:0]        width_reg;

    // history
    logic signed [31:0] older_reg [3];
    logic signed [31:0] newer_reg [3];
    logic [1:0]         seen_reg;

    // current item
    logic signed [31:0] p_reg [3];
    logic               fin_reg;
    logic               phase_reg;

    // current pair job
    logic signed [31:0] pt_reg [3];
    logic signed [32:0] d_reg  [3];
    logic               last_reg;
    logic [32:0]        ax_reg, ay_reg;
    logic [63:0]        s_reg;
    logic [63:0]        rn_reg, rr_reg, bit_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        div_num_reg;
    logic [34:0]        div_rem_reg;
    logic [34:0]        div_den_reg;
    logic [31:0]        qxm_reg;
    logic [31:0]        qy_reg;
    logic signed [32:0] ox_reg, oy_reg;
    prbeo_pkg::pair_t   out_reg;

    // job selection
    logic signed [31:0] sel_pt [3];
    logic signed [32:0] sel_d  [3];
    logic               sel_last;
    logic               more_pairs;

    // shared units
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] mul_rnd;
    logic [35:0] rem_sh;
    logic        div_ge;
    logic [34:0] rem_nx;
    logic [63:0] root_sum;
    logic [32:0] mx;
    logic        zero_xy;
    logic [32:0] q_round;
    logic [31:0] az, axp;
    logic [33:0] glow_n;
    logic [63:0] glow_num;
    logic [34:0] glow_den;
    logic signed [32:0] qym_s, qxm_s;

    // handshake
    assign point_ready = (state_reg == prbeo_pkg::S_IDLE);
    assign pair_valid  = (state_reg == prbeo_pkg::S_OUT);
    assign pair        = out_reg;
    assign more_pairs  = !phase_reg && fin_reg && (seen_reg != 2'd0);

    // pick base point and tangent for this pair
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (phase_reg)
            begin
                sel_pt[i] = p_reg[i];
                sel_d[i]  = 33'(p_reg[i]) - 33'(out_ctrl_reg[i]);
            end
            else if (seen_reg == 2'd0)
            begin
                sel_pt[i] = p_reg[i];
                sel_d[i]  = 33'(in_ctrl_reg[i]) - 33'(p_reg[i]);
            end
            else if (seen_reg == 2'd1)
            begin
                sel_pt[i] = newer_reg[i];
                sel_d[i]  = 33'(in_ctrl_reg[i]) - 33'(newer_reg[i]);
            end
            else
            begin
                sel_pt[i] = newer_reg[i];
                sel_d[i]  = 33'(p_reg[i]) - 33'(older_reg[i]);
            end
        end
        sel_last = phase_reg || (seen_reg == 2'd0);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            prbeo_pkg::S_SQX:
            begin
                mul_a = ax_reg[31:0];
                mul_b = ax_reg[31:0];
            end
            prbeo_pkg::S_SQY:
            begin
                mul_a = ay_reg[31:0];
                mul_b = ay_reg[31:0];
            end
            prbeo_pkg::S_MULX:
            begin
                mul_a = {1'b0, width_reg};
                mul_b = q_round[31:0];
            end
            prbeo_pkg::S_MULY:
            begin
                mul_a = {1'b0, width_reg};
                mul_b = qy_reg;
            end
            prbeo_pkg::S_VMUL:
            begin
                mul_a = {1'b0, width_reg};
                mul_b = prbeo_pkg::INV_SQRT2_Q30;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign mul_rnd = (mul_p + prbeo_pkg::ROUND_Q30) >> 30;

    // restoring divider step
    assign rem_sh = {div_rem_reg, div_num_reg[63]};
    assign div_ge = rem_sh >= {1'b0, div_den_reg};
    assign rem_nx = div_ge ? 35'(rem_sh - {1'b0, div_den_reg}) : rem_sh[34:0];
    assign q_round = 33'(({1'b0, div_num_reg[32:0]} + 34'd1) >> 1);

    // square root step
    assign root_sum = rr_reg + bit_reg;

    // normalising and tangent tests
    assign mx      = (ax_reg > ay_reg) ? ax_reg : ay_reg;
    assign zero_xy = (sel_d[0] == '0) && (sel_d[1] == '0);

    // intensity operands
    assign az  = pt_reg[2][31] ? 32'(-pt_reg[2]) : 32'(pt_reg[2]);
    assign axp = pt_reg[0][31] ? 32'(-pt_reg[0]) : 32'(pt_reg[0]);
    assign glow_n = (pt_reg[0][31] == pt_reg[2][31])
                  ? ({1'b0, az, 1'b0} + 34'(div_rem_reg[31:0]))
                  : ({1'b0, az, 1'b0} - 34'(div_rem_reg[31:0]));
    assign glow_num = (64'(glow_n) << 17) + 64'(az) + (64'(az) << 1);
    assign glow_den = (35'(az) << 2) + (35'(az) << 1);

    assign qym_s = {1'b0, mul_rnd[31:0]};
    assign qxm_s = {1'b0, qxm_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prbeo_pkg::S_IDLE:
                if (point_valid)
                    state_next = (seen_reg == 2'd0 && !point.is_final)
                               ? prbeo_pkg::S_IDLE : prbeo_pkg::S_PREP;
            prbeo_pkg::S_PREP:
                if (zero_xy)
                    state_next = (sel_d[2] != '0) ? prbeo_pkg::S_VMUL : prbeo_pkg::S_GLOW;
                else
                    state_next = prbeo_pkg::S_NORM;
            prbeo_pkg::S_NORM:
                if (mx[32:31] == 2'b00 && mx[30])
                    state_next = prbeo_pkg::S_SQX;
            prbeo_pkg::S_SQX:  state_next = prbeo_pkg::S_SQY;
            prbeo_pkg::S_SQY:  state_next = prbeo_pkg::S_ROOT;
            prbeo_pkg::S_ROOT:
                if (cnt_reg == '0)
                    state_next = prbeo_pkg::S_DIVX;
            prbeo_pkg::S_DIVX:
                if (cnt_reg == '0)
                    state_next = prbeo_pkg::S_MULX;
            prbeo_pkg::S_MULX: state_next = prbeo_pkg::S_DIVY;
            prbeo_pkg::S_DIVY:
                if (cnt_reg == '0)
                    state_next = prbeo_pkg::S_MULY;
            prbeo_pkg::S_MULY: state_next = prbeo_pkg::S_GLOW;
            prbeo_pkg::S_VMUL: state_next = prbeo_pkg::S_GLOW;
            prbeo_pkg::S_GLOW:
                state_next = (pt_reg[2] == '0) ? prbeo_pkg::S_OUT : prbeo_pkg::S_GMOD;
            prbeo_pkg::S_GMOD:
                if (cnt_reg == '0)
                    state_next = prbeo_pkg::S_GDIV;
            prbeo_pkg::S_GDIV:
                if (cnt_reg == '0)
                    state_next = prbeo_pkg::S_OUT;
            prbeo_pkg::S_OUT:
                if (pair_ready)
                    state_next = more_pairs ? prbeo_pkg::S_PREP : prbeo_pkg::S_IDLE;
            default: state_next = prbeo_pkg::S_IDLE;
        endcase
    end

    // control state, configuration and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prbeo_pkg::S_IDLE;
            seen_reg  <= 2'd0;
            phase_reg <= 1'b0;
            width_reg <= prbeo_pkg::WIDTH_RESET;
            for (int i = 0; i < 3; i++)
            begin
                in_ctrl_reg[i]  <= '0;
                out_ctrl_reg[i] <= '0;
                older_reg[i]    <= '0;
                newer_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    prbeo_pkg::REG_IN_CTRL_X:  in_ctrl_reg[0]  <= cfg_data;
                    prbeo_pkg::REG_IN_CTRL_Y:  in_ctrl_reg[1]  <= cfg_data;
                    prbeo_pkg::REG_IN_CTRL_Z:  in_ctrl_reg[2]  <= cfg_data;
                    prbeo_pkg::REG_OUT_CTRL_X: out_ctrl_reg[0] <= cfg_data;
                    prbeo_pkg::REG_OUT_CTRL_Y: out_ctrl_reg[1] <= cfg_data;
                    prbeo_pkg::REG_OUT_CTRL_Z: out_ctrl_reg[2] <= cfg_data;
                    prbeo_pkg::REG_WIDTH:      width_reg       <= cfg_data[30:0];
                    default: ;
                endcase
            end
            // a first point of a polyline that is not final only gets stored
            if (state_reg == prbeo_pkg::S_IDLE && point_valid)
            begin
                phase_reg <= 1'b0;
                if (seen_reg == 2'd0 && !point.is_final)
                begin
                    newer_reg[0] <= point.point_x;
                    newer_reg[1] <= point.point_y;
                    newer_reg[2] <= point.point_z;
                    seen_reg     <= 2'd1;
                end
            end
            // history update once the pair transfer completes
            if (state_reg == prbeo_pkg::S_OUT && pair_ready)
            begin
                if (more_pairs)
                    phase_reg <= 1'b1;
                else if (fin_reg)
                begin
                    seen_reg <= 2'd0;
                    for (int i = 0; i < 3; i++)
                    begin
                        older_reg[i] <= '0;
                        newer_reg[i] <= '0;
                    end
                end
                else
                begin
                    seen_reg <= 2'd2;
                    for (int i = 0; i < 3; i++)
                    begin
                        older_reg[i] <= newer_reg[i];
                        newer_reg[i] <= p_reg[i];
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            prbeo_pkg::S_IDLE:
                if (point_valid)
                begin
                    p_reg[0] <= point.point_x;
                    p_reg[1] <= point.point_y;
                    p_reg[2] <= point.point_z;
                    fin_reg  <= point.is_final;
                end
            prbeo_pkg::S_PREP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pt_reg[i] <= sel_pt[i];
                    d_reg[i]  <= sel_d[i];
                end
                last_reg <= sel_last;
                ax_reg   <= sel_d[0][32] ? 33'(-sel_d[0]) : 33'(sel_d[0]);
                ay_reg   <= sel_d[1][32] ? 33'(-sel_d[1]) : 33'(sel_d[1]);
                ox_reg   <= '0;
                oy_reg   <= '0;
            end
            prbeo_pkg::S_NORM:
                if (mx[32:31] != 2'b00)
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end
                else if (!mx[30])
                begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                end
            prbeo_pkg::S_SQX:
                s_reg <= mul_p;
            prbeo_pkg::S_SQY:
            begin
                rn_reg  <= s_reg + mul_p;
                rr_reg  <= '0;
                bit_reg <= 64'd1 << 62;
                cnt_reg <= prbeo_pkg::ROOT_STEPS;
            end
            prbeo_pkg::S_ROOT:
                if (cnt_reg != '0)
                begin
                    if (rn_reg >= root_sum)
                    begin
                        rn_reg <= rn_reg - root_sum;
                        rr_reg <= (rr_reg >> 1) + bit_reg;
                    end
                    else
                        rr_reg <= rr_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 6'd1;
                end
                else
                begin
                    // x component: (ax << 31) / L
                    div_den_reg <= 35'(rr_reg[31:0]);
                    div_num_reg <= {ax_reg[1:0], 62'd0};
                    div_rem_reg <= 35'(ax_reg[30:2]);
                    cnt_reg     <= prbeo_pkg::QDIV_STEPS;
                end
            prbeo_pkg::S_DIVX, prbeo_pkg::S_DIVY, prbeo_pkg::S_GMOD:
                if (cnt_reg != '0)
                begin
                    div_rem_reg <= rem_nx;
                    div_num_reg <= {div_num_reg[62:0], div_ge};
                    cnt_reg     <= cnt_reg - 6'd1;
                end
                else if (state_reg == prbeo_pkg::S_DIVY)
                    qy_reg <= q_round[31:0];
                else if (state_reg == prbeo_pkg::S_GMOD)
                begin
                    div_den_reg <= glow_den;
                    div_num_reg <= {glow_num[17:0], 46'd0};
                    div_rem_reg <= 35'(glow_num[51:18]);
                    cnt_reg     <= prbeo_pkg::GDIV_STEPS;
                end
            prbeo_pkg::S_MULX:
            begin
                qxm_reg     <= mul_rnd[31:0];
                div_num_reg <= {ay_reg[1:0], 62'd0};
                div_rem_reg <= 35'(ay_reg[30:2]);
                cnt_reg     <= prbeo_pkg::QDIV_STEPS;
            end
            prbeo_pkg::S_MULY:
            begin
                ox_reg <= (d_reg[1] > 0) ? -qym_s : qym_s;
                oy_reg <= (d_reg[0] > 0) ? qxm_s : -qxm_s;
            end
            prbeo_pkg::S_VMUL:
            begin
                ox_reg <= (d_reg[2] > 0) ? -qym_s : qym_s;
                oy_reg <= (d_reg[2] > 0) ? qym_s : -qym_s;
            end
            prbeo_pkg::S_GLOW:
            begin
                out_reg.base_x    <= pt_reg[0];
                out_reg.base_y    <= pt_reg[1];
                out_reg.base_z    <= pt_reg[2];
                out_reg.edge_x    <= 32'(33'(pt_reg[0]) + ox_reg);
                out_reg.edge_y    <= 32'(33'(pt_reg[1]) + oy_reg);
                out_reg.edge_z    <= pt_reg[2];
                out_reg.last_pair <= last_reg;
                out_reg.glow      <= prbeo_pkg::GLOW_ZERO_Z;
                // remainder of |x| by |z|
                div_den_reg <= 35'(az);
                div_num_reg <= {axp, 32'd0};
                div_rem_reg <= '0;
                cnt_reg     <= prbeo_pkg::MOD_STEPS;
            end
            prbeo_pkg::S_GDIV:
                if (cnt_reg != '0)
                begin
                    div_rem_reg <= rem_nx;
                    div_num_reg <= {div_num_reg[62:0], div_ge};
                    cnt_reg     <= cnt_reg - 6'd1;
                end
                else
                    out_reg.glow <= (div_num_reg[17:16] != 2'b00) ? 16'hFFFF
                                                                  : div_num_reg[15:0];
            default: ;
        endcase
    end

    // checks
    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("history count out of range");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(point_ready && pair_valid))
        else $error("input ready while a pair waits");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && pair_ready && pair.last_pair) |=> (seen_reg == 2'd0))
        else $error("history not cleared after last pair");

    a_phase_final: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && state_reg == prbeo_pkg::S_OUT) |-> (fin_reg && out_reg.last_pair))
        else $error("second pair without final point");

endmodule

// ===== verif/tb_polyline_ribbon_edge_offset_top.sv =====
// Testbench for the polyline ribbon edge offset block
// Depends on prbeo_pkg and polyline_ribbon_edge_offset_top; checks pairs on a local predictor
`timescale 1ns / 1ps
module tb_polyline_ribbon_edge_offset_top;

    logic                clk;
    logic                rst_n;
    logic                point_valid;
    logic                point_ready;
    prbeo_pkg::point_t   point;
    logic                pair_valid;
    logic                pair_ready;
    prbeo_pkg::pair_t    pair;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_data;

    polyline_ribbon_edge_offset_top dut (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    longint    ctl_in [3];
    longint    ctl_out [3];
    longint    rib_width;
    longint    prev_pt [3];
    longint    last_pt [3];
    int        pts_held;

    prbeo_pkg::pair_t pending_pairs [$];
    int        mismatches;
    int        pairs_seen;
    int        points_sent;
    bit        hold_long;
    prbeo_pkg::pair_t table_pair;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // integer square root, bit pairs
    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] glow_for(longint x, longint z);
        longint unsigned az;
        longint unsigned rm;
        longint unsigned g;
        longint n;
        if (z == 0) return prbeo_pkg::GLOW_ZERO_Z;
        az = (z < 0) ? -z : z;
        rm = ((x < 0) ? -x : x) % az;
        n = 2 * longint'(az) + (((x < 0) == (z < 0)) ? longint'(rm) : -longint'(rm));
        g = (unsigned'(n) * 131072 + 3 * az) / (6 * az);
        return (g > 65535) ? 16'hffff : g[15:0];
    endfunction

    // build one pair for point p with tangent d
    function automatic prbeo_pkg::pair_t ribbon_pair(longint p [3], longint dx, longint dy,
                                                     longint dz, bit fin);
        prbeo_pkg::pair_t r;
        longint ox;
        longint oy;
        longint m;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned mx;
        longint unsigned l;
        longint unsigned qx;
        longint unsigned qy;
        longint unsigned w;
        ox = 0;
        oy = 0;
        w = rib_width;
        if (dx == 0 && dy == 0)
        begin
            if (dz != 0)
            begin
                m = (w * 759250125 + (64'd1 << 29)) >> 30;
                ox = (dz > 0) ? -m : m;
                oy = -ox;
            end
        end
        else
        begin
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            mx = (ax > ay) ? ax : ay;
            while (mx >= (64'd1 << 31)) begin ax >>= 1; ay >>= 1; mx >>= 1; end
            while (mx < (64'd1 << 30)) begin ax <<= 1; ay <<= 1; mx <<= 1; end
            l = root64(ax * ax + ay * ay);
            qx = (((ax << 31) / l) + 1) >> 1;
            qy = (((ay << 31) / l) + 1) >> 1;
            qx = (w * qx + (64'd1 << 29)) >> 30;
            qy = (w * qy + (64'd1 << 29)) >> 30;
            ox = (dy > 0) ? -longint'(qy) : longint'(qy);
            oy = (dx > 0) ? longint'(qx) : -longint'(qx);
        end
        r.base_x = p[0][31:0];
        r.base_y = p[1][31:0];
        r.base_z = p[2][31:0];
        r.edge_x = 32'(p[0] + ox);
        r.edge_y = 32'(p[1] + oy);
        r.edge_z = p[2][31:0];
        r.glow = glow_for(p[0], p[2]);
        r.last_pair = fin;
        return r;
    endfunction

    // append one expected pair at the tail
    task automatic queue_pair(prbeo_pkg::pair_t pr);
        pending_pairs.insert(pending_pairs.size(), pr);
    endtask

    task automatic predict_point(prbeo_pkg::point_t pt);
        longint p [3];
        p[0] = pt.point_x;
        p[1] = pt.point_y;
        p[2] = pt.point_z;
        if (pts_held == 0)
        begin
            if (pt.is_final)
                queue_pair(ribbon_pair(p, ctl_in[0] - p[0], ctl_in[1] - p[1],
                                       ctl_in[2] - p[2], 1'b1));
            else
            begin
                last_pt = p;
                pts_held = 1;
            end
            return;
        end
        if (pts_held == 1)
            queue_pair(ribbon_pair(last_pt, ctl_in[0] - last_pt[0],
                ctl_in[1] - last_pt[1], ctl_in[2] - last_pt[2], 1'b0));
        else
            queue_pair(ribbon_pair(last_pt, p[0] - prev_pt[0],
                p[1] - prev_pt[1], p[2] - prev_pt[2], 1'b0));
        if (pt.is_final)
        begin
            queue_pair(ribbon_pair(p, p[0] - ctl_out[0], p[1] - ctl_out[1],
                                   p[2] - ctl_out[2], 1'b1));
            prev_pt = '{0, 0, 0};
            last_pt = '{0, 0, 0};
            pts_held = 0;
        end
        else
        begin
            prev_pt = last_pt;
            last_pt = p;
            pts_held = 2;
        end
    endtask

    // output side: check every transfer
    always @(posedge clk)
    begin
        if (rst_n && pair_valid && pair_ready)
        begin
            prbeo_pkg::pair_t exp_pair;
            pairs_seen = pairs_seen + 1;
            if (pending_pairs.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected pair %h", pair);
            end
            else
            begin
                exp_pair = pending_pairs.pop_front();
                if (pair !== exp_pair)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("pair mismatch: expected %h actual %h", exp_pair, pair);
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            pair_ready <= 1'b0;
        else if (hold_long)
            pair_ready <= 1'b0;
        else
            pair_ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        int cnt;
        hold_long = 1'b0;
        #30000;
        @(posedge clk);
        hold_long = 1'b1;
        cnt = 0;
        while (cnt < 3000)
        begin
            @(posedge clk);
            cnt++;
        end
        hold_long = 1'b0;
    end

    // one register write; the enable stays up for a following write
    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx < prbeo_pkg::REG_OUT_CTRL_X) ctl_in[idx] = longint'(signed'(val));
        else if (idx < prbeo_pkg::REG_WIDTH)
            ctl_out[idx - prbeo_pkg::REG_OUT_CTRL_X] = longint'(signed'(val));
        else rib_width = val[30:0];
    endtask

    task automatic cfg_done();
        cfg_we <= 1'b0;
    endtask

    // offer one point and wait for its transfer; valid stays up for a following point
    task automatic send_point(prbeo_pkg::point_t pt);
        point_valid <= 1'b1;
        point <= pt;
        @(posedge clk);
        while (!point_ready) @(posedge clk);
        predict_point(pt);
        points_sent++;
    endtask

    // drop valid and idle for a number of cycles
    task automatic idle_input(int cycles);
        point_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_pairs();
        int cnt;
        point_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
        cnt = 0;
        while (cnt < 400)
        begin
            @(posedge clk);
            cnt++;
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return $urandom_range(0, 200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        fin;
    } stim_row_t;

    stim_row_t stim_table [12] = '{
        '{32'd0, 32'd0, 32'd0, 1'b1},                          // zero tangent, zero z
        '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1},  // single point
        '{32'd0, 32'd0, 32'h0001_0000, 1'b0},                  // vertical tangent
        '{32'd0, 32'd0, 32'h0002_0000, 1'b0},
        '{32'd0, 32'd0, 32'hffff_0000, 1'b1},
        '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0},  // extremes
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0},
        '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b0},
        '{32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 1'b1},
        '{32'h0005_0000, 32'h0000_0000, 32'h0003_0000, 1'b0},
        '{32'h0005_0000, 32'h0000_0000, 32'h0003_0000, 1'b0},  // repeated point
        '{32'h0005_0000, 32'h0000_0000, 32'h0003_0000, 1'b1}
    };

    initial
    begin
        prbeo_pkg::point_t pt;
        int gap;
        int plen;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        cfg_we = 1'b0;
        cfg_index = prbeo_pkg::REG_IN_CTRL_X;
        cfg_data = '0;
        mismatches = 0;
        pairs_seen = 0;
        points_sent = 0;
        ctl_in = '{0, 0, 0};
        ctl_out = '{0, 0, 0};
        rib_width = prbeo_pkg::WIDTH_RESET;
        prev_pt = '{0, 0, 0};
        last_pt = '{0, 0, 0};
        pts_held = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: the single point after reset reads off at a glance
        table_pair = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                       prbeo_pkg::GLOW_ZERO_Z, 1'b1};
        pt = '{stim_table[0].x, stim_table[0].y, stim_table[0].z, stim_table[0].fin};
        send_point(pt);
        if (pending_pairs[0] !== table_pair)
        begin
            mismatches++;
            $display("predictor disagrees with table after reset");
        end
        for (int i = 1; i < $size(stim_table); i++)
        begin
            pt = '{stim_table[i].x, stim_table[i].y, stim_table[i].z, stim_table[i].fin};
            send_point(pt);
        end
        drain_pairs();

        // extremes of the registers
        cfg_write(prbeo_pkg::REG_IN_CTRL_X, 32'h7fff_ffff);
        cfg_write(prbeo_pkg::REG_IN_CTRL_Y, 32'h8000_0000);
        cfg_write(prbeo_pkg::REG_IN_CTRL_Z, 32'hffff_ffff);
        cfg_write(prbeo_pkg::REG_OUT_CTRL_X, 32'h8000_0000);
        cfg_write(prbeo_pkg::REG_OUT_CTRL_Y, 32'h7fff_ffff);
        cfg_write(prbeo_pkg::REG_OUT_CTRL_Z, 32'h0000_0001);
        cfg_write(prbeo_pkg::REG_WIDTH, 32'h7fff_ffff);
        cfg_done();
        for (int i = 0; i < $size(stim_table); i++)
        begin
            pt = '{stim_table[i].x, stim_table[i].y, stim_table[i].z, stim_table[i].fin};
            send_point(pt);
        end
        drain_pairs();
        cfg_write(prbeo_pkg::REG_WIDTH, 32'd0);
        cfg_done();
        pt = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1};
        send_point(pt);
        drain_pairs();

        // random phases with fresh settings each time
        for (int phase = 0; phase < 8; phase++)
        begin
            cfg_write(prbeo_pkg::REG_IN_CTRL_X, rand_coord());
            cfg_write(prbeo_pkg::REG_IN_CTRL_Y, rand_coord());
            cfg_write(prbeo_pkg::REG_IN_CTRL_Z, rand_coord());
            cfg_write(prbeo_pkg::REG_OUT_CTRL_X, rand_coord());
            cfg_write(prbeo_pkg::REG_OUT_CTRL_Y, rand_coord());
            cfg_write(prbeo_pkg::REG_OUT_CTRL_Z, rand_coord());
            cfg_write(prbeo_pkg::REG_WIDTH, (phase == 7) ? 32'h7fff_ffff
                                                         : ($urandom >> $urandom_range(1, 16)));
            cfg_done();
            for (int k = 0; k < 50; k++)
            begin
                plen = $urandom_range(0, 6);
                pt.point_x = rand_coord();
                pt.point_y = rand_coord();
                pt.point_z = rand_coord();
                pt.is_final = (plen == 0) || ($urandom_range(0, 5) == 0);
                send_point(pt);
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 200) : 0;
                if (gap != 0) idle_input(gap);
            end
            // close any open polyline before the registers change
            pt = '{rand_coord(), rand_coord(), rand_coord(), 1'b1};
            send_point(pt);
            drain_pairs();
        end

        drain_pairs();
        $display("sent %0d points, checked %0d pairs", points_sent, pairs_seen);
        $display("settings: reset values, extreme registers, zero width, 8 random sets");
        if (mismatches == 0)
            $display("tb_polyline_ribbon_edge_offset_top: done, clean");
        else
            $display("tb_polyline_ribbon_edge_offset_top: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #9000000;
        $display("tb_polyline_ribbon_edge_offset_top: done, errors");
        $finish;
    end

endmodule
